// ===== rtl/priority_ready_ring_defines.svh =====
// ----------------------------------------------------------------------------
// priority_ready_ring assertion macros
// Clocked on clk and disabled in rst; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_RING_DEFINES_SVH
`define PRIORITY_READY_RING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PRR_ASSERT(lbl, prop, msg)
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/prr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_pkg
// Types, sizes and helpers shared by the ready queue cells and control.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int TASKS     = 16;
  localparam int PRIO_BITS = 8;
  localparam int TASK_W    = 8;
  localparam int REQ_W     = 8;
  localparam int IDX_W     = $clog2(TASKS);
  localparam int CNT_W     = $clog2(TASKS + 1);

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_PRIO = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_ROT_FWD  = 3'd4,
    OP_ROT_BACK = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SEL_KEEP = 3'd0,
    SEL_PREV = 3'd1,
    SEL_NEXT = 3'd2,
    SEL_NEW  = 3'd3,
    SEL_HEAD = 3'd4,
    SEL_TAIL = 3'd5
  } sel_t;

  typedef struct packed {
    logic [TASK_W-1:0]    task_id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] task_id;
    logic [REQ_W-1:0]  priority_req;
  } cmd_t;

  typedef struct packed {
    logic [TASK_W-1:0] head_task;
    logic              head_valid;
    logic [CNT_W-1:0]  entry_total;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic cell_higher;
    logic new_higher;
    logic id_match;
  } flag_t;

  typedef struct packed {
    logic [CNT_W-1:0] count_next;
    status_t          status;
  } scan_t;

  // bits 0..upto set
  function automatic logic [TASKS-1:0] low_mask(input int unsigned upto);
    logic [TASKS-1:0] m;
    for (int j = 0; j < TASKS; j++) begin
      m[j] = (j <= upto);
    end
    return m;
  endfunction

endpackage

// ===== rtl/priority_ready_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_ring
// Ready queue of task entries kept in queue order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the command transfers at a
//   clock edge with start high and busy low. busy stays low, so one command
//   can transfer in every cycle.
//   Result channel: done is high for one cycle, the cycle after the command
//   transferred, with result (head task, head valid, count, status) for that
//   command. The receiver cannot stall; a result is shown exactly once.
//   Throughput is one command per cycle: every cell
//   compares against the request and loads from a neighbor in the same
//   cycle, and the place search is a prefix over the cell flags.
//   Config channel: cfg_data (larger value is higher when set) transfers on
//   cfg_valid and cfg_ready; cfg_ready is always high. Write it while idle.
//   Reset (rst, synchronous) empties the queue and sets the config bit to 1;
//   entry contents are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
`include "priority_ready_ring_defines.svh"

module priority_ready_ring import prr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data
);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_m1;
  logic               larger_hi;
  status_t            status;
  entry_t             new_entry;
  entry_t             tail_entry;
  entry_t [TASKS-1:0] cells;
  flag_t  [TASKS-1:0] flags;
  sel_t   [TASKS-1:0] sel;
  sel_t   [TASKS-1:0] sel_go;
  scan_t              scan;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign new_entry.task_id = cmd.task_id;
  assign new_entry.prio    = cmd.priority_req[PRIO_BITS-1:0];
  assign count_m1          = count - CNT_W'(1);
  assign tail_entry        = cells[count_m1[IDX_W-1:0]];

  always_comb begin
    for (int i = 0; i < TASKS; i++) begin
      sel_go[i] = start ? sel[i] : SEL_KEEP;
    end
  end

  prr_scan u_scan (
    .op    (cmd.op),
    .count (count),
    .flags (flags),
    .sel   (sel),
    .scan  (scan)
  );

  for (genvar g = 0; g < TASKS; g++) begin : g_cell
    entry_t prev_entry;
    entry_t next_entry;

    if (g == 0) begin : g_first
      assign prev_entry = cells[g];
    end else begin : g_mid
      assign prev_entry = cells[g-1];
    end

    if (g == TASKS - 1) begin : g_last
      assign next_entry = cells[g];
    end else begin : g_rest
      assign next_entry = cells[g+1];
    end

    prr_cell u_cell (
      .clk        (clk),
      .sel        (sel_go[g]),
      .new_entry  (new_entry),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .head_entry (cells[0]),
      .tail_entry (tail_entry),
      .larger_hi  (larger_hi),
      .entry      (cells[g]),
      .flags      (flags[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      larger_hi <= 1'b1;
      done      <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= scan.count_next;
      end
      if (cfg_valid && cfg_ready) begin
        larger_hi <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      status <= scan.status;
    end
  end

  always_comb begin
    result.head_valid  = (count != '0);
    result.head_task   = result.head_valid ? cells[0].task_id : '0;
    result.entry_total = count;
    result.status      = status;
  end

  `PRR_ASSERT(a_count_max, count <= CNT_W'(TASKS), "entry count above capacity")
  `PRR_ASSERT_NEXT(a_done_follows, start && !busy, done, "no result strobe after transfer")
  `PRR_ASSERT_NEXT(a_full_hold, start && !busy && count == CNT_W'(TASKS) && (cmd.op == OP_INS_HEAD || cmd.op == OP_INS_TAIL || cmd.op == OP_INS_PRIO), $stable(count), "insert into full queue changed count")
  `PRR_ASSERT_NEXT(a_rotate_hold, start && !busy && (cmd.op == OP_ROT_FWD || cmd.op == OP_ROT_BACK), $stable(count), "rotate changed count")

endmodule

// ===== rtl/prr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_cell
// One queue place: holds an entry, compares it against the incoming request
// and loads from itself, a neighbor, the head, the tail or the new entry.
// ----------------------------------------------------------------------------
module prr_cell import prr_pkg::*; (
  input  logic   clk,
  input  sel_t   sel,
  input  entry_t new_entry,
  input  entry_t prev_entry,
  input  entry_t next_entry,
  input  entry_t head_entry,
  input  entry_t tail_entry,
  input  logic   larger_hi,
  output entry_t entry,
  output flag_t  flags
);

  entry_t entry_next;

  always_comb begin
    flags.cell_higher = larger_hi ? (entry.prio > new_entry.prio)
                                  : (entry.prio < new_entry.prio);
    flags.new_higher  = larger_hi ? (new_entry.prio > entry.prio)
                                  : (new_entry.prio < entry.prio);
    flags.id_match    = (entry.task_id == new_entry.task_id);
  end

  always_comb begin
    unique case (sel)
      SEL_KEEP: entry_next = entry;
      SEL_PREV: entry_next = prev_entry;
      SEL_NEXT: entry_next = next_entry;
      SEL_NEW:  entry_next = new_entry;
      SEL_HEAD: entry_next = head_entry;
      SEL_TAIL: entry_next = tail_entry;
      default:  entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/prr_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_scan
// Collects the cell flags, finds the insert or remove place and issues a
// load select to every cell, with the new count and status.
// ----------------------------------------------------------------------------
module prr_scan import prr_pkg::*; (
  input  op_t                    op,
  input  logic [CNT_W-1:0]       count,
  input  flag_t [TASKS-1:0]      flags,
  output sel_t [TASKS-1:0]       sel,
  output scan_t                  scan
);

  logic [TASKS-1:0] occ;
  logic [TASKS-1:0] walk;
  logic [TASKS-1:0] nh;
  logic [TASKS-1:0] match;
  logic [TASKS-1:0] cont;
  logic [TASKS-1:0] cont_prev;
  logic [TASKS-1:0] rm_pre;
  logic [TASKS-1:0] le;
  logic [TASKS-1:0] le_prev;
  logic             found;
  logic             full;
  logic             empty;
  logic             ins;

  always_comb begin
    for (int i = 0; i < TASKS; i++) begin
      occ[i]   = CNT_W'(i) < count;
      walk[i]  = ((CNT_W'(i) + CNT_W'(1)) < count) && flags[i].cell_higher;
      nh[i]    = flags[i].new_higher;
      match[i] = occ[i] && flags[i].id_match;
    end
    for (int i = 0; i < TASKS; i++) begin
      cont[i]   = &(walk | ~low_mask(i));
      rm_pre[i] = |(match & low_mask(i));
    end
    cont_prev = {cont[TASKS-2:0], 1'b1};
    found     = |match;
    full      = (count == CNT_W'(TASKS));
    empty     = (count == '0);

    ins = 1'b0;
    le  = '0;
    unique case (op)
      OP_INS_HEAD: begin
        ins = 1'b1;
        le  = '1;
      end
      OP_INS_TAIL: begin
        ins = 1'b1;
        le  = ~occ;
      end
      OP_INS_PRIO: begin
        ins = 1'b1;
        le  = empty ? '1 : (~cont_prev | (~cont & nh));
      end
      default: begin
        ins = 1'b0;
      end
    endcase
    le_prev = {le[TASKS-2:0], 1'b0};

    for (int i = 0; i < TASKS; i++) begin
      sel[i] = SEL_KEEP;
    end
    scan.count_next = count;
    scan.status     = ST_DONE;

    if (ins) begin
      if (full) begin
        scan.status = ST_FULL;
      end else begin
        scan.count_next = count + CNT_W'(1);
        for (int i = 0; i < TASKS; i++) begin
          if (le[i]) begin
            sel[i] = le_prev[i] ? SEL_PREV : SEL_NEW;
          end
        end
      end
    end else begin
      unique case (op)
        OP_REMOVE: begin
          if (found) begin
            scan.count_next = count - CNT_W'(1);
            for (int i = 0; i < TASKS; i++) begin
              if (rm_pre[i]) begin
                sel[i] = SEL_NEXT;
              end
            end
          end else begin
            scan.status = ST_NOT_FOUND;
          end
        end
        OP_ROT_FWD: begin
          if (!empty) begin
            for (int i = 0; i < TASKS; i++) begin
              if ((CNT_W'(i) + CNT_W'(1)) < count) begin
                sel[i] = SEL_NEXT;
              end else if ((CNT_W'(i) + CNT_W'(1)) == count) begin
                sel[i] = SEL_HEAD;
              end
            end
          end
        end
        OP_ROT_BACK: begin
          if (!empty) begin
            sel[0] = SEL_TAIL;
            for (int i = 1; i < TASKS; i++) begin
              if (occ[i]) begin
                sel[i] = SEL_PREV;
              end
            end
          end
        end
        default: begin
          scan.status = ST_DONE;
        end
      endcase
    end
  end

endmodule
